@@ rtl/cia_pkg.sv @@
package cia_pkg;

    localparam int RES_W = 32;

    typedef logic signed [RES_W-1:0] t_res;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_cia_op;

    typedef enum logic {
        ST_OK       = 1'b0,
        ST_DIV_ZERO = 1'b1
    } t_cia_status;

endpackage

@@ rtl/cia_if.sv @@
interface cia_in_if #(
    parameter int OPERAND_WIDTH = 16
);
    import cia_pkg::*;

    logic                            valid;
    logic                            ready;
    t_cia_op                         req_type;
    logic signed [OPERAND_WIDTH-1:0] a_re;
    logic signed [OPERAND_WIDTH-1:0] a_im;
    logic signed [OPERAND_WIDTH-1:0] b_re;
    logic signed [OPERAND_WIDTH-1:0] b_im;

    modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cia_out_if;
    import cia_pkg::*;

    logic        valid;
    logic        ready;
    t_res        res_re;
    t_res        res_im;
    t_cia_status status;

    modport source (output valid, res_re, res_im, status, input ready);
    modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

@@ rtl/complex_integer_alu_unit.sv @@
// Complex integer arithmetic unit: add, subtract, multiply or divide two complex operands
// of OPERAND_WIDTH bits per part, giving 32-bit wrapped real and imaginary parts and a
// divide-by-zero status. One item is accepted per cycle unless the pipeline holds; each
// item passes from input to output register through one multiply stage, one
// sum stage, one magnitude stage, OPERAND_WIDTH + 1 restoring divider stages that each
// resolve one quotient bit, and the output register. The whole pipeline holds while a
// finished item waits at the output, and moves again as soon as it is taken.
module complex_integer_alu_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cia_in_if.sink    i_in,
    cia_out_if.source o_out
);
    import cia_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int NB = 2 * W;
    localparam int QB = W + 1;
    localparam int TW = NB + QB;

    typedef struct packed {
        t_cia_op         op;
        t_res            pre_re;
        t_res            pre_im;
        logic            sgn_re;
        logic            sgn_im;
        logic            dz;
        logic [NB-1:0]   den;
        logic [NB-1:0]   rem_re;
        logic [NB-1:0]   rem_im;
        logic [QB-1:0]   q_re;
        logic [QB-1:0]   q_im;
    } t_dv;

    logic w_en;

    // stage a: products and add/subtract
    logic                 r_a_vld;
    t_cia_op              r_a_op;
    t_res                 r_a_pre_re, n_a_pre_re;
    t_res                 r_a_pre_im, n_a_pre_im;
    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bb, r_p_bi;

    // stage b: sums
    logic                 r_b_vld;
    t_cia_op              r_b_op;
    t_res                 r_b_pre_re, n_b_pre_re;
    t_res                 r_b_pre_im, n_b_pre_im;
    logic signed [SW-1:0] r_b_nre, n_b_nre;
    logic signed [SW-1:0] r_b_nim, n_b_nim;
    logic [NB-1:0]        r_b_den, n_b_den;
    logic signed [SW-1:0] w_mul_re, w_mul_im;

    // stage c and divider steps
    logic r_dv_vld [0:QB];
    t_dv  r_dv     [0:QB];
    t_dv  n_dv     [0:QB];

    // output register
    logic        r_out_vld;
    t_res        r_out_re, n_out_re;
    t_res        r_out_im, n_out_im;
    t_cia_status r_out_st, n_out_st;
    logic signed [QB:0] w_qre, w_qim;

    assign w_en       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    always_comb begin
        n_a_pre_re = '0;
        n_a_pre_im = '0;
        case (i_in.req_type)
            OP_ADD: begin
                n_a_pre_re = RES_W'((W+1)'(i_in.a_re) + (W+1)'(i_in.b_re));
                n_a_pre_im = RES_W'((W+1)'(i_in.a_im) + (W+1)'(i_in.b_im));
            end
            OP_SUB: begin
                n_a_pre_re = RES_W'((W+1)'(i_in.a_re) - (W+1)'(i_in.b_re));
                n_a_pre_im = RES_W'((W+1)'(i_in.a_im) - (W+1)'(i_in.b_im));
            end
            default: begin
                n_a_pre_re = '0;
                n_a_pre_im = '0;
            end
        endcase
    end

    always_comb begin
        w_mul_re   = SW'(r_p_rr) - SW'(r_p_ii);
        w_mul_im   = SW'(r_p_ri) + SW'(r_p_ir);
        n_b_nre    = SW'(r_p_rr) + SW'(r_p_ii);
        n_b_nim    = SW'(r_p_ir) - SW'(r_p_ri);
        n_b_den    = NB'($unsigned(r_p_bb)) + NB'($unsigned(r_p_bi));
        n_b_pre_re = r_a_pre_re;
        n_b_pre_im = r_a_pre_im;
        if (r_a_op == OP_MUL) begin
            n_b_pre_re = RES_W'(w_mul_re);
            n_b_pre_im = RES_W'(w_mul_im);
        end
    end

    always_comb begin
        n_dv[0].op     = r_b_op;
        n_dv[0].pre_re = r_b_pre_re;
        n_dv[0].pre_im = r_b_pre_im;
        n_dv[0].sgn_re = r_b_nre[SW-1];
        n_dv[0].sgn_im = r_b_nim[SW-1];
        n_dv[0].dz     = (r_b_den == '0);
        n_dv[0].den    = r_b_den;
        n_dv[0].rem_re = NB'(r_b_nre[SW-1] ? -r_b_nre : r_b_nre);
        n_dv[0].rem_im = NB'(r_b_nim[SW-1] ? -r_b_nim : r_b_nim);
        n_dv[0].q_re   = '0;
        n_dv[0].q_im   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_dv_vld[0] <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld   <= i_in.valid;
            r_b_vld   <= r_a_vld;
            r_dv_vld[0] <= r_b_vld;
            r_out_vld <= r_dv_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_op     <= i_in.req_type;
            r_a_pre_re <= n_a_pre_re;
            r_a_pre_im <= n_a_pre_im;
            r_p_rr     <= PW'(i_in.a_re) * PW'(i_in.b_re);
            r_p_ii     <= PW'(i_in.a_im) * PW'(i_in.b_im);
            r_p_ri     <= PW'(i_in.a_re) * PW'(i_in.b_im);
            r_p_ir     <= PW'(i_in.a_im) * PW'(i_in.b_re);
            r_p_bb     <= PW'(i_in.b_re) * PW'(i_in.b_re);
            r_p_bi     <= PW'(i_in.b_im) * PW'(i_in.b_im);
            r_b_op     <= r_a_op;
            r_b_pre_re <= n_b_pre_re;
            r_b_pre_im <= n_b_pre_im;
            r_b_nre    <= n_b_nre;
            r_b_nim    <= n_b_nim;
            r_b_den    <= n_b_den;
            r_dv[0]    <= n_dv[0];
            r_out_re   <= n_out_re;
            r_out_im   <= n_out_im;
            r_out_st   <= n_out_st;
        end
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar k = 1; k <= QB; k++) begin : g_div
        localparam int SH = QB - k;
        logic [TW-1:0] w_dsh;
        logic          w_ge_re;
        logic          w_ge_im;

        always_comb begin
            w_dsh   = TW'(r_dv[k-1].den) << SH;
            w_ge_re = TW'(r_dv[k-1].rem_re) >= w_dsh;
            w_ge_im = TW'(r_dv[k-1].rem_im) >= w_dsh;
            n_dv[k] = r_dv[k-1];
            n_dv[k].q_re[SH] = w_ge_re;
            n_dv[k].q_im[SH] = w_ge_im;
            if (w_ge_re) begin
                n_dv[k].rem_re = r_dv[k-1].rem_re - NB'(w_dsh);
            end
            if (w_ge_im) begin
                n_dv[k].rem_im = r_dv[k-1].rem_im - NB'(w_dsh);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    always_comb begin
        w_qre = r_dv[QB].sgn_re ? -$signed({1'b0, r_dv[QB].q_re})
                                : $signed({1'b0, r_dv[QB].q_re});
        w_qim = r_dv[QB].sgn_im ? -$signed({1'b0, r_dv[QB].q_im})
                                : $signed({1'b0, r_dv[QB].q_im});
        n_out_re = r_dv[QB].pre_re;
        n_out_im = r_dv[QB].pre_im;
        n_out_st = ST_OK;
        if (r_dv[QB].op == OP_DIV) begin
            if (r_dv[QB].dz) begin
                n_out_re = '0;
                n_out_im = '0;
                n_out_st = ST_DIV_ZERO;
            end else begin
                n_out_re = RES_W'(w_qre);
                n_out_im = RES_W'(w_qim);
            end
        end
    end

    assign o_out.valid  = r_out_vld;
    assign o_out.res_re = r_out_re;
    assign o_out.res_im = r_out_im;
    assign o_out.status = r_out_st;

    a_zero_on_div_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == ST_DIV_ZERO |-> o_out.res_re == '0 && o_out.res_im == '0)
        else $error("divide error item with nonzero result");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_in.ready)
        else $error("input stalled while output register empty");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[QB] && !r_dv[QB].dz |->
            r_dv[QB].rem_re < r_dv[QB].den && r_dv[QB].rem_im < r_dv[QB].den)
        else $error("divider remainder not below divisor");

endmodule

@@ bench/cia_result_checker.sv @@
module cia_result_checker #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cia_in_if    i_req_mon,
    cia_out_if   i_res_mon,
    output int   o_mismatches,
    output int   o_outstanding
);
    import cia_pkg::*;

    typedef logic signed [OPERAND_WIDTH-1:0] t_operand;

    typedef struct packed {
        t_res        re;
        t_res        im;
        t_cia_status status;
    } t_answer;

    t_answer expected_answers[$];
    int      mismatch_count = 0;
    int      answers_waiting = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = answers_waiting;

    function automatic t_answer compute_answer(t_cia_op op, t_operand a_re, t_operand a_im,
                                               t_operand b_re, t_operand b_im);
        longint  ar;
        longint  ai;
        longint  br;
        longint  bi;
        longint  re;
        longint  im;
        longint  mag;
        t_answer ans;
        ar = a_re;
        ai = a_im;
        br = b_re;
        bi = b_im;
        re = 0;
        im = 0;
        ans.status = ST_OK;
        case (op)
            OP_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            OP_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            OP_MUL: begin
                re = ar * br - ai * bi;
                im = ar * bi + ai * br;
            end
            default: begin
                mag = br * br + bi * bi;
                if (mag == 0) begin
                    ans.status = ST_DIV_ZERO;
                end else begin
                    re = (ar * br + ai * bi) / mag;
                    im = (ai * br - ar * bi) / mag;
                end
            end
        endcase
        ans.re = t_res'(re);
        ans.im = t_res'(im);
        return ans;
    endfunction

    task automatic note_mismatch(string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (expected_answers.size() == 0) begin
                    note_mismatch("result with no item pending");
                end else begin
                    want = expected_answers.pop_front();
                    if (i_res_mon.res_re !== want.re)
                        note_mismatch($sformatf("res_re got %0d want %0d",
                                                i_res_mon.res_re, want.re));
                    if (i_res_mon.res_im !== want.im)
                        note_mismatch($sformatf("res_im got %0d want %0d",
                                                i_res_mon.res_im, want.im));
                    if (i_res_mon.status !== want.status)
                        note_mismatch($sformatf("status got %0d want %0d",
                                                i_res_mon.status, want.status));
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                expected_answers.push_back(compute_answer(i_req_mon.req_type,
                                                          i_req_mon.a_re, i_req_mon.a_im,
                                                          i_req_mon.b_re, i_req_mon.b_im));
            end
        end
        answers_waiting = expected_answers.size();
    end

endmodule

@@ bench/complex_integer_alu_unit_test.sv @@
module complex_integer_alu_unit_test;
    import cia_pkg::*;

    localparam int OPERAND_WIDTH = 16;
    localparam int LATENCY       = OPERAND_WIDTH + 5;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 120;

    typedef logic signed [OPERAND_WIDTH-1:0] t_operand;

    localparam t_operand OPND_MAX = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};
    localparam t_operand OPND_MIN = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   gaps_on = 1'b1;
    bit   stalls_on = 1'b1;
    int   sent_items = 0;
    int   mismatches;
    int   outstanding;

    cia_in_if #(.OPERAND_WIDTH(OPERAND_WIDTH)) req_if ();
    cia_out_if res_if ();

    complex_integer_alu_unit #(.OPERAND_WIDTH(OPERAND_WIDTH)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_if.sink),
        .o_out   (res_if.source)
    );

    cia_result_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) result_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_mon     (req_if),
        .i_res_mon     (res_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

    // result side: random stalls plus one long hold that backs up the pipeline
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && sent_items >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= !(stalls_on && $urandom_range(99) < 21);
            end
        end
    end

    function automatic t_operand pick_operand();
        int small_val;
        small_val = $urandom_range(32);
        case ($urandom_range(9))
            0:       return OPND_MAX;
            1:       return OPND_MIN;
            2:       return '0;
            3, 4:    return t_operand'(small_val - 16);
            default: return t_operand'($urandom);
        endcase
    endfunction

    task automatic offer_item(t_cia_op op, t_operand a_re, t_operand a_im,
                              t_operand b_re, t_operand b_im);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 21) begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= op;
        req_if.a_re     <= a_re;
        req_if.a_im     <= a_im;
        req_if.b_re     <= b_re;
        req_if.b_im     <= b_im;
        do @(posedge clk); while (!req_if.ready);
        sent_items++;
    endtask

    initial begin
        t_cia_op  op;
        t_operand br;
        t_operand bi;
        req_if.valid    = 1'b0;
        req_if.req_type = OP_ADD;
        req_if.a_re     = '0;
        req_if.a_im     = '0;
        req_if.b_re     = '0;
        req_if.b_im     = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        offer_item(OP_ADD, OPND_MAX, OPND_MAX, OPND_MAX, OPND_MAX);
        offer_item(OP_ADD, OPND_MIN, OPND_MIN, OPND_MIN, OPND_MIN);
        offer_item(OP_ADD, 1, -1, -1, 1);
        offer_item(OP_SUB, OPND_MIN, OPND_MAX, OPND_MAX, OPND_MIN);
        offer_item(OP_SUB, OPND_MAX, OPND_MIN, OPND_MIN, OPND_MAX);
        offer_item(OP_SUB, 0, 0, OPND_MIN, OPND_MIN);
        // imaginary part of this product wraps past 32 bits
        offer_item(OP_MUL, OPND_MIN, OPND_MIN, OPND_MIN, OPND_MIN);
        offer_item(OP_MUL, OPND_MAX, OPND_MAX, OPND_MAX, OPND_MAX);
        offer_item(OP_MUL, OPND_MAX, OPND_MIN, OPND_MIN, OPND_MAX);
        offer_item(OP_MUL, 0, 0, 0, 0);
        offer_item(OP_MUL, 3, 4, 3, -4);
        // zero magnitude divisor
        offer_item(OP_DIV, 0, 0, 0, 0);
        offer_item(OP_DIV, OPND_MAX, OPND_MIN, 0, 0);
        // quotients truncate toward zero
        offer_item(OP_DIV, 7, -7, 2, 0);
        offer_item(OP_DIV, -7, 7, 0, 2);
        offer_item(OP_DIV, OPND_MIN, OPND_MIN, 1, 1);
        offer_item(OP_DIV, OPND_MAX, OPND_MIN, 1, 0);
        offer_item(OP_DIV, OPND_MIN, OPND_MAX, -1, 0);
        offer_item(OP_DIV, OPND_MIN, OPND_MIN, OPND_MIN, OPND_MIN);
        offer_item(OP_DIV, 1, 1, OPND_MAX, OPND_MAX);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            gaps_on   = !(n >= 500 && n < 800);
            stalls_on = gaps_on;
            op = t_cia_op'($urandom_range(3));
            br = pick_operand();
            bi = pick_operand();
            if (op == OP_DIV && $urandom_range(15) == 0) begin
                br = '0;
                bi = '0;
            end
            offer_item(op, pick_operand(), pick_operand(), br, bi);
        end
        @(negedge clk);
        req_if.valid <= 1'b0;

        wait (outstanding == 0);
        repeat (2 * LATENCY) @(negedge clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
